// ===== sv/mcst_pkg.sv =====
// mcst_pkg: shared types and constants of the stepper tone generator
// used by mcst_note_table, mcst_channel and multi_channel_stepper_tone_generator
// no dependencies
package mcst_pkg;

	// field widths fixed by the stream format
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned DELTA_W  = 16;
	localparam int unsigned CMD_W    = 8;
	localparam int unsigned TIDX_W   = 5;
	localparam int unsigned PERIOD_W = 20;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned LINE_W   = 8;
	localparam int unsigned CHAN_W   = 3;
	localparam int unsigned S_DATA_W = 56;
	localparam int unsigned M_DATA_W = 24;

	// ignore byte, travel limit reset value and elapsed counter ceiling
	localparam logic [CMD_W-1:0]    IGNORE_BYTE   = 8'hFF;
	localparam logic [POS_W-1:0]    TRAVEL_RESET  = 8'd144;
	localparam logic [PERIOD_W-1:0] ELAPSED_MAX   = '1;

	// request kinds carried in tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_TICK   = 2'd0,
		KIND_CMD    = 2'd1,
		KIND_TABLE  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_STEP_MODE    = 1'b0,
		CFG_TRAVEL_LIMIT = 1'b1
	} cfg_index_t;

	// stepping modes
	localparam logic MODE_OSCILLATE = 1'b0;

	// per-channel update strobes
	typedef struct packed {
		logic tick;
		logic load;
		logic led_on;
	} chan_ctrl_t;

	// per-channel line levels after the update
	typedef struct packed {
		logic step;
		logic dir;
		logic led;
	} chan_lines_t;

endpackage

// ===== sv/mcst_note_table.sv =====
// mcst_note_table: note period table, one write port, one combinational read port
// depends on mcst_pkg
// entries clear to silent at reset
module mcst_note_table #(
	parameter int unsigned NOTE_COUNT = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [mcst_pkg::TIDX_W-1:0]    wr_index,
	input  logic [mcst_pkg::PERIOD_W-1:0]  wr_period,
	input  logic [mcst_pkg::TIDX_W-1:0]    rd_note,
	output logic                           rd_hit,
	output logic [mcst_pkg::PERIOD_W-1:0]  rd_period
);

	localparam int unsigned IDX_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;

	logic [mcst_pkg::PERIOD_W-1:0] periods_q [NOTE_COUNT];
	logic                          wr_hit;

	// range checks on both ports
	assign wr_hit = ({1'b0, wr_index} < (mcst_pkg::TIDX_W + 1)'(NOTE_COUNT));
	assign rd_hit = ({1'b0, rd_note} < (mcst_pkg::TIDX_W + 1)'(NOTE_COUNT));

	// table storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NOTE_COUNT; i++) begin
				periods_q[i] <= '0;
			end
		end else if (wr_en && wr_hit) begin
			periods_q[wr_index[IDX_W-1:0]] <= wr_period;
		end
	end

	// read mux
	assign rd_period = rd_hit ? periods_q[rd_note[IDX_W-1:0]] : '0;

endmodule

// ===== sv/mcst_channel.sv =====
// mcst_channel: one stepper channel, period counter and step/direction state
// depends on mcst_pkg
// lines_nx gives the levels after this cycle's update
module mcst_channel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcst_pkg::chan_ctrl_t           ctrl,
	input  logic [mcst_pkg::DELTA_W-1:0]   delta,
	input  logic [mcst_pkg::PERIOD_W-1:0]  load_period,
	input  logic                           step_mode,
	input  logic [mcst_pkg::POS_W-1:0]     travel_limit,
	output mcst_pkg::chan_lines_t          lines_nx
);

	logic [mcst_pkg::PERIOD_W-1:0] period_q;
	logic [mcst_pkg::PERIOD_W-1:0] elapsed_q;
	logic [mcst_pkg::POS_W-1:0]    pos_q;
	logic                          dir_q;
	logic                          step_q;
	logic                          led_q;

	logic [mcst_pkg::PERIOD_W:0]   sum;
	logic [mcst_pkg::PERIOD_W-1:0] sum_sat;
	logic                          counting;
	logic                          fire;
	logic                          slide_dir;
	logic [mcst_pkg::PERIOD_W-1:0] elapsed_d;
	logic [mcst_pkg::PERIOD_W-1:0] period_d;
	logic [mcst_pkg::POS_W-1:0]    pos_d;
	logic                          dir_d;
	logic                          step_d;
	logic                          led_d;

	// saturating counter add and period compare
	assign sum      = {1'b0, elapsed_q} + (mcst_pkg::PERIOD_W + 1)'(delta);
	assign sum_sat  = sum[mcst_pkg::PERIOD_W] ? mcst_pkg::ELAPSED_MAX
	                                          : sum[mcst_pkg::PERIOD_W-1:0];
	assign counting = ctrl.tick && (period_q != '0);
	assign fire     = counting && (sum_sat >= period_q);

	// bounce between the travel ends
	always_comb begin
		if (pos_q >= travel_limit) begin
			slide_dir = 1'b1;
		end else if (pos_q == '0) begin
			slide_dir = 1'b0;
		end else begin
			slide_dir = dir_q;
		end
	end

	// next state
	always_comb begin
		period_d  = period_q;
		led_d     = led_q;
		elapsed_d = elapsed_q;
		pos_d     = pos_q;
		dir_d     = dir_q;
		step_d    = step_q;
		if (ctrl.load) begin
			period_d = load_period;
			led_d    = ctrl.led_on;
		end
		if (counting) begin
			elapsed_d = fire ? '0 : sum_sat;
		end
		if (fire) begin
			step_d = ~step_q;
			if (step_mode == mcst_pkg::MODE_OSCILLATE) begin
				dir_d = dir_q ^ step_q;
			end else begin
				dir_d = slide_dir;
				pos_d = slide_dir ? pos_q - 1'b1 : pos_q + 1'b1;
			end
		end
	end

	// channel state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= '0;
			elapsed_q <= '0;
			pos_q     <= '0;
			dir_q     <= 1'b0;
			step_q    <= 1'b0;
			led_q     <= 1'b0;
		end else begin
			period_q  <= period_d;
			elapsed_q <= elapsed_d;
			pos_q     <= pos_d;
			dir_q     <= dir_d;
			step_q    <= step_d;
			led_q     <= led_d;
		end
	end

	assign lines_nx = '{step: step_d, dir: dir_d, led: led_d};

endmodule

// ===== sv/multi_channel_stepper_tone_generator.sv =====
// multi_channel_stepper_tone_generator: top level, input register, channel array, result register
// depends on mcst_pkg, mcst_note_table and mcst_channel
// one result per request with the step, direction and led lines
//
// Takes one request per clock cycle while the output is not stalled. Every request goes through an
// input register, the channel and note table update happens as it leaves that register, and the
// line levels after that update leave through a result register. All channels update in parallel;
// s_tready follows m_tready whenever both stages are full. Line bits for channels at or beyond
// CHANNELS read as zero. Configuration writes take effect at once and are meant for an idle block.
module multi_channel_stepper_tone_generator #(
	parameter int unsigned CHANNELS   = 8,
	parameter int unsigned NOTE_COUNT = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [0:0]                      cfg_index,
	input  logic [mcst_pkg::POS_W-1:0]      cfg_data,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// tdata: elapsed_us[15:0], command_byte[23:16], table_index[28:24],
	//        table_period[48:29], zero fill [55:49]
	input  logic [mcst_pkg::S_DATA_W-1:0]   s_tdata,
	// tuser: kind[1:0]
	input  logic [mcst_pkg::KIND_W-1:0]     s_tuser,
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tdata: step_lines[7:0], direction_lines[15:8], led_lines[23:16]
	output logic [mcst_pkg::M_DATA_W-1:0]   m_tdata
);

	logic                            step_mode_q;
	logic [mcst_pkg::POS_W-1:0]      travel_limit_q;

	logic                            valid_s1;
	mcst_pkg::kind_t                 kind_s1;
	logic [mcst_pkg::DELTA_W-1:0]    delta_s1;
	logic [mcst_pkg::CMD_W-1:0]      cmd_s1;
	logic [mcst_pkg::TIDX_W-1:0]     tidx_s1;
	logic [mcst_pkg::PERIOD_W-1:0]   tper_s1;

	logic                            m_tvalid_q;
	logic [mcst_pkg::M_DATA_W-1:0]   m_tdata_q;

	logic                            advance;
	logic                            do_tick;
	logic                            do_cmd;
	logic                            do_table;
	logic [mcst_pkg::TIDX_W-1:0]     cmd_note;
	logic [mcst_pkg::CHAN_W-1:0]     cmd_chan;
	logic                            chan_hit;
	logic                            note_hit;
	logic                            cmd_ok;
	logic [mcst_pkg::PERIOD_W-1:0]   note_period;

	logic [mcst_pkg::LINE_W-1:0]     step_nx;
	logic [mcst_pkg::LINE_W-1:0]     dir_nx;
	logic [mcst_pkg::LINE_W-1:0]     led_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_mode_q    <= mcst_pkg::MODE_OSCILLATE;
			travel_limit_q <= mcst_pkg::TRAVEL_RESET;
		end else if (cfg_we) begin
			unique case (mcst_pkg::cfg_index_t'(cfg_index))
				mcst_pkg::CFG_STEP_MODE:    step_mode_q    <= cfg_data[0];
				mcst_pkg::CFG_TRAVEL_LIMIT: travel_limit_q <= cfg_data;
				default:                    step_mode_q    <= step_mode_q;
			endcase
		end
	end

	// stage handshake
	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1  <= mcst_pkg::kind_t'(s_tuser);
			delta_s1 <= s_tdata[15:0];
			cmd_s1   <= s_tdata[23:16];
			tidx_s1  <= s_tdata[28:24];
			tper_s1  <= s_tdata[48:29];
		end
	end

	// request decode
	always_comb begin
		do_tick  = 1'b0;
		do_cmd   = 1'b0;
		do_table = 1'b0;
		unique case (kind_s1)
			mcst_pkg::KIND_TICK:   do_tick  = advance;
			mcst_pkg::KIND_CMD:    do_cmd   = advance;
			mcst_pkg::KIND_TABLE:  do_table = advance;
			mcst_pkg::KIND_UNUSED: do_tick  = 1'b0;
			default:               do_tick  = 1'b0;
		endcase
	end

	// command byte fields and range checks
	assign cmd_note = cmd_s1[7:3];
	assign cmd_chan = cmd_s1[2:0];
	assign chan_hit = ({1'b0, cmd_chan} < (mcst_pkg::CHAN_W + 1)'(CHANNELS));
	assign cmd_ok   = do_cmd && (cmd_s1 != mcst_pkg::IGNORE_BYTE) && chan_hit && note_hit;

	mcst_note_table #(
		.NOTE_COUNT (NOTE_COUNT)
	) u_note_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (do_table),
		.wr_index  (tidx_s1),
		.wr_period (tper_s1),
		.rd_note   (cmd_note),
		.rd_hit    (note_hit),
		.rd_period (note_period)
	);

	// channel array, unused line bits tied low
	for (genvar c = 0; c < mcst_pkg::LINE_W; c++) begin : g_chan
		if (c < CHANNELS) begin : g_on
			mcst_pkg::chan_ctrl_t  ctrl;
			mcst_pkg::chan_lines_t lines;

			assign ctrl = '{
				tick:   do_tick,
				load:   cmd_ok && (cmd_chan == mcst_pkg::CHAN_W'(c)),
				led_on: (cmd_note != '0)
			};

			mcst_channel u_channel (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctrl         (ctrl),
				.delta        (delta_s1),
				.load_period  (note_period),
				.step_mode    (step_mode_q),
				.travel_limit (travel_limit_q),
				.lines_nx     (lines)
			);

			assign step_nx[c] = lines.step;
			assign dir_nx[c]  = lines.dir;
			assign led_nx[c]  = lines.led;
		end else begin : g_off
			assign step_nx[c] = 1'b0;
			assign dir_nx[c]  = 1'b0;
			assign led_nx[c]  = 1'b0;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {led_nx, dir_nx, step_nx};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== test/multi_channel_stepper_tone_generator_test.sv =====
// multi_channel_stepper_tone_generator_test: self-checking bench for the stepper tone generator
// depends on mcst_pkg and multi_channel_stepper_tone_generator
// predicts the step, direction and led lines per request and checks them against the results
module multi_channel_stepper_tone_generator_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH     = 8;
	localparam int NUM_NOTES  = 32;
	localparam int IDLE_PCT   = 21;
	localparam int TAIL_WAIT  = 10;
	localparam int CYCLE_LIMIT = 200000;

	// one request as carried on the slave side
	typedef struct packed {
		mcst_pkg::kind_t                kind;
		logic [mcst_pkg::DELTA_W-1:0]   elapsed_us;
		logic [mcst_pkg::CMD_W-1:0]     command_byte;
		logic [mcst_pkg::TIDX_W-1:0]    table_index;
		logic [mcst_pkg::PERIOD_W-1:0]  table_period;
	} tone_req_t;

	// result layout, step lines in the lowest bits
	typedef struct packed {
		logic [mcst_pkg::LINE_W-1:0] led_lines;
		logic [mcst_pkg::LINE_W-1:0] direction_lines;
		logic [mcst_pkg::LINE_W-1:0] step_lines;
	} lines_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [0:0]                      cfg_index = mcst_pkg::CFG_STEP_MODE;
	logic [mcst_pkg::POS_W-1:0]      cfg_data = '0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [mcst_pkg::S_DATA_W-1:0]   s_tdata = '0;
	logic [mcst_pkg::KIND_W-1:0]     s_tuser = mcst_pkg::KIND_TICK;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [mcst_pkg::M_DATA_W-1:0]   m_tdata;

	tone_req_t pending_requests[$];
	lines_t    expected_lines[$];
	tone_req_t held_req;
	logic      calm = 1'b0;
	int        errors = 0;
	int        cycles = 0;

	// shadow of the block state
	logic                           mode_now;
	logic [mcst_pkg::POS_W-1:0]     limit_now;
	logic [mcst_pkg::PERIOD_W-1:0]  ch_period [NUM_CH];
	logic [mcst_pkg::PERIOD_W-1:0]  ch_elapsed [NUM_CH];
	logic [mcst_pkg::POS_W-1:0]     head_pos [NUM_CH];
	logic                           head_dir [NUM_CH];
	logic                           step_lvl [NUM_CH];
	logic                           led_lvl [NUM_CH];
	logic [mcst_pkg::PERIOD_W-1:0]  note_period [NUM_NOTES];

	multi_channel_stepper_tone_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #6 clk = ~clk;

	// one half step of a channel in the current mode
	function automatic void half_step(int c);
		if (mode_now == mcst_pkg::MODE_OSCILLATE) begin
			if (step_lvl[c])
				head_dir[c] = ~head_dir[c];
			step_lvl[c] = ~step_lvl[c];
		end else begin
			if (head_pos[c] >= limit_now)
				head_dir[c] = 1'b1;
			else if (head_pos[c] == '0)
				head_dir[c] = 1'b0;
			step_lvl[c] = ~step_lvl[c];
			if (head_dir[c])
				head_pos[c] = head_pos[c] - 1'b1;
			else
				head_pos[c] = head_pos[c] + 1'b1;
		end
	endfunction

	// apply one request to the shadow state and return the lines after it
	function automatic lines_t predict_lines(tone_req_t req);
		logic [mcst_pkg::PERIOD_W:0] sum;
		logic [4:0]                  note;
		logic [2:0]                  ch;
		lines_t                      res;
		case (req.kind)
			mcst_pkg::KIND_TICK: begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (ch_period[c] != '0) begin
						sum = {1'b0, ch_elapsed[c]} + req.elapsed_us;
						if (sum > {1'b0, mcst_pkg::ELAPSED_MAX})
							sum = {1'b0, mcst_pkg::ELAPSED_MAX};
						if (sum[mcst_pkg::PERIOD_W-1:0] >= ch_period[c]) begin
							half_step(c);
							ch_elapsed[c] = '0;
						end else begin
							ch_elapsed[c] = sum[mcst_pkg::PERIOD_W-1:0];
						end
					end
				end
			end
			mcst_pkg::KIND_CMD: begin
				note = req.command_byte[7:3];
				ch = req.command_byte[2:0];
				if (req.command_byte != mcst_pkg::IGNORE_BYTE && ch < NUM_CH
						&& note < NUM_NOTES) begin
					ch_period[ch] = note_period[note];
					led_lvl[ch] = (note != '0);
				end
			end
			mcst_pkg::KIND_TABLE: begin
				if (req.table_index < NUM_NOTES)
					note_period[req.table_index] = req.table_period;
			end
			default: ;
		endcase
		res = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			res.step_lines[c] = step_lvl[c];
			res.direction_lines[c] = head_dir[c];
			res.led_lines[c] = led_lvl[c];
		end
		return res;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// request source: every field random, the used ones set after
	function automatic tone_req_t noise_request(mcst_pkg::kind_t k);
		tone_req_t r;
		r.kind = k;
		r.elapsed_us = mcst_pkg::DELTA_W'($urandom);
		r.command_byte = mcst_pkg::CMD_W'($urandom);
		r.table_index = mcst_pkg::TIDX_W'($urandom);
		r.table_period = mcst_pkg::PERIOD_W'($urandom);
		return r;
	endfunction

	function automatic void queue_tick(logic [mcst_pkg::DELTA_W-1:0] us);
		tone_req_t r;
		r = noise_request(mcst_pkg::KIND_TICK);
		r.elapsed_us = us;
		pending_requests.push_back(r);
	endfunction

	function automatic void queue_command(logic [mcst_pkg::CMD_W-1:0] cmd);
		tone_req_t r;
		r = noise_request(mcst_pkg::KIND_CMD);
		r.command_byte = cmd;
		pending_requests.push_back(r);
	endfunction

	function automatic void queue_table(logic [mcst_pkg::TIDX_W-1:0] idx,
			logic [mcst_pkg::PERIOD_W-1:0] per);
		tone_req_t r;
		r = noise_request(mcst_pkg::KIND_TABLE);
		r.table_index = idx;
		r.table_period = per;
		pending_requests.push_back(r);
	endfunction

	// mostly short periods so that ticks step the heads often
	function automatic logic [mcst_pkg::PERIOD_W-1:0] rand_period();
		int b;
		b = $urandom_range(99);
		if (b < 8)
			return '0;
		else if (b < 70)
			return mcst_pkg::PERIOD_W'($urandom_range(3000, 1));
		else if (b < 88)
			return mcst_pkg::PERIOD_W'($urandom_range(150000, 3001));
		return mcst_pkg::PERIOD_W'($urandom_range(20'hFFFFF, 150001));
	endfunction

	function automatic logic [mcst_pkg::DELTA_W-1:0] rand_elapsed();
		int b;
		b = $urandom_range(99);
		if (b < 5)
			return '0;
		else if (b < 65)
			return mcst_pkg::DELTA_W'($urandom_range(2000, 1));
		else if (b < 88)
			return mcst_pkg::DELTA_W'($urandom_range(16'hFFFF, 0));
		return 16'hFFFF;
	endfunction

	// load some notes and channels, then a random mix dominated by ticks
	function automatic void queue_random(int n);
		int b;
		for (int i = 0; i < 6; i++)
			queue_table(mcst_pkg::TIDX_W'($urandom), rand_period());
		for (int i = 0; i < 5; i++)
			queue_command({5'($urandom_range(31, 1)), 3'($urandom)});
		for (int i = 0; i < n; i++) begin
			b = $urandom_range(99);
			if (b < 55)
				queue_tick(rand_elapsed());
			else if (b < 70)
				queue_command(mcst_pkg::CMD_W'($urandom));
			else if (b < 73)
				queue_command(mcst_pkg::IGNORE_BYTE);
			else if (b < 88)
				queue_table(mcst_pkg::TIDX_W'($urandom), rand_period());
			else if (b < 92)
				pending_requests.push_back(noise_request(mcst_pkg::KIND_UNUSED));
			else
				queue_tick(16'hFFFF);
		end
	endfunction

	task automatic write_register(mcst_pkg::cfg_index_t idx, logic [mcst_pkg::POS_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == mcst_pkg::CFG_STEP_MODE)
			mode_now = val[0];
		else
			limit_now = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_requests.size() != 0 || s_tvalid || expected_lines.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic run_phase(logic mode, logic [mcst_pkg::POS_W-1:0] lim, int n, logic quiet);
		wait_idle();
		write_register(mcst_pkg::CFG_STEP_MODE, {{(mcst_pkg::POS_W-1){1'b0}}, mode});
		write_register(mcst_pkg::CFG_TRAVEL_LIMIT, lim);
		@(negedge clk);
		calm = quiet;
		queue_random(n);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_lines.push_back(predict_lines(held_req));
			if (!s_tvalid || s_tready) begin
				if (pending_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					held_req <= pending_requests[0];
					s_tdata <= {{(mcst_pkg::S_DATA_W-49){1'b0}},
						pending_requests[0].table_period,
						pending_requests[0].table_index, pending_requests[0].command_byte,
						pending_requests[0].elapsed_us};
					s_tuser <= pending_requests[0].kind;
					void'(pending_requests.pop_front());
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and output stall
	always @(posedge clk) begin
		lines_t exp_l;
		lines_t act_l;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				act_l = lines_t'(m_tdata);
				if (expected_lines.size() == 0) begin
					$display("%0t: result %h with none expected", $time, m_tdata);
					errors++;
				end else begin
					exp_l = expected_lines.pop_front();
					check_field("step_lines", exp_l.step_lines, act_l.step_lines);
					check_field("direction_lines", exp_l.direction_lines,
						act_l.direction_lines);
					check_field("led_lines", exp_l.led_lines, act_l.led_lines);
				end
			end
			m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("multi_channel_stepper_tone_generator_test: errors");
			$finish;
		end
	end

	initial begin
		mode_now = mcst_pkg::MODE_OSCILLATE;
		limit_now = mcst_pkg::TRAVEL_RESET;
		for (int c = 0; c < NUM_CH; c++) begin
			ch_period[c] = '0;
			ch_elapsed[c] = '0;
			head_pos[c] = '0;
			head_dir[c] = 1'b0;
			step_lvl[c] = 1'b0;
			led_lvl[c] = 1'b0;
		end
		for (int i = 0; i < NUM_NOTES; i++)
			note_period[i] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, silent channels, extremes and ignored requests
		pending_requests.push_back(noise_request(mcst_pkg::KIND_UNUSED));
		queue_tick(16'hFFFF);
		queue_table(5'd0, 20'd5);
		queue_table(5'd31, 20'hFFFFF);
		queue_table(5'd2, 20'd3);
		queue_table(5'd1, 20'd0);
		// note zero counts but leaves the led off
		queue_command({5'd0, 3'd0});
		queue_command({5'd31, 3'd6});
		queue_command({5'd2, 3'd1});
		queue_command(mcst_pkg::IGNORE_BYTE);
		queue_tick(16'd0);
		queue_tick(16'd3);
		queue_tick(16'd2);
		queue_tick(16'd7);
		// table rewrite leaves the copied period alone
		queue_table(5'd2, 20'd100);
		queue_tick(16'd3);
		// silent note with the led on, counter kept
		queue_command({5'd1, 3'd1});
		repeat (5) queue_tick(16'hFFFF);
		queue_random(140);

		// random phases across the mode and limit settings
		run_phase(1'b1, 8'd4, 160, 1'b0);
		run_phase(1'b1, 8'd255, 160, 1'b1);
		run_phase(1'b0, 8'd1, 150, 1'b0);
		run_phase(1'b1, 8'd1, 150, 1'b0);
		run_phase(1'b1, 8'd0, 120, 1'b0);
		run_phase(1'b1, mcst_pkg::POS_W'($urandom_range(254, 2)), 160, 1'b0);
		run_phase(1'b0, mcst_pkg::TRAVEL_RESET, 150, 1'b0);

		wait_idle();
		repeat (TAIL_WAIT) @(negedge clk);
		if (errors == 0)
			$display("multi_channel_stepper_tone_generator_test: clean");
		else
			$display("multi_channel_stepper_tone_generator_test: errors");
		$finish;
	end

endmodule
